/* rtl/core/decimal_text_to_fixed_point_defines.svh */
// Assertion macros used by the checker file of the decimal text parser.
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DTFP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dtfp checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define DTFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dtfp checker: next-cycle property failed");

`endif

/* rtl/core/dtfp_pkg.sv */
`default_nettype none

package dtfp_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned COUNT_BITS = 16;

  // The integer part never exceeds 2^(VALUE_BITS-1).
  localparam int unsigned ACC_BITS   = VALUE_BITS;
  localparam int unsigned ACC_X_BITS = ACC_BITS + 4;
  // Kept fraction digits stay at or below 999.
  localparam int unsigned FRAC_BITS  = 10;
  // Integer part times 100 plus a rounded fraction of up to 100.
  localparam int unsigned MAG_BITS   = VALUE_BITS + 7;
  localparam int unsigned RND_BITS   = 7;

  // x / 10 == (x * 205) >> 11 for every x below 1029.
  localparam int unsigned RECIP       = 205;
  localparam int unsigned RECIP_SHIFT = 11;
  localparam int unsigned RPROD_BITS  = FRAC_BITS + 1 + 8;

  localparam logic [MAG_BITS-1:0] MAG_CAP = MAG_BITS'(1) << (VALUE_BITS - 1);

  typedef enum logic [1:0] {
    MODE_TWO_DEC = 2'd0,
    MODE_ONE_DEC = 2'd1,
    MODE_INTEGER = 2'd2
  } mode_e;

  // Code 3 on the configuration port is taken as integer mode.
  localparam logic [1:0] MODE_CODE_ALIAS = 2'd3;

  localparam logic [1:0] KEPT_TWO_DEC = 2'd3;
  localparam logic [1:0] KEPT_ONE_DEC = 2'd2;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic                 negative;
    logic                 point_seen;
    logic [1:0]           frac_count;
    logic [FRAC_BITS-1:0] frac_digits;
    logic [ACC_BITS-1:0]  acc;
    logic                 saturated;
  } parse_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  overflow;
  } scaled_t;

endpackage

`default_nettype wire

/* rtl/core/dtfp_scale.sv */
`default_nettype none

module dtfp_scale (
  input  dtfp_pkg::mode_e   mode_i,
  input  dtfp_pkg::parse_t  parse_i,
  output dtfp_pkg::scaled_t scaled_o
);

  logic [1:0]                        kept;
  logic [1:0]                        missing;
  logic [dtfp_pkg::FRAC_BITS-1:0]    frac_pad;
  logic [dtfp_pkg::FRAC_BITS:0]      rnd_sum;
  logic [dtfp_pkg::RPROD_BITS-1:0]   rprod;
  logic [dtfp_pkg::RND_BITS-1:0]     rnd;
  logic [dtfp_pkg::MAG_BITS-1:0]     mag;
  logic [dtfp_pkg::MAG_BITS-1:0]     limit;
  logic [dtfp_pkg::MAG_BITS-1:0]     mag_sel;
  logic [dtfp_pkg::VALUE_BITS-1:0]   mag_low;
  logic                              ovf;

  always_comb begin
    kept    = (mode_i == dtfp_pkg::MODE_TWO_DEC) ? dtfp_pkg::KEPT_TWO_DEC
                                                 : dtfp_pkg::KEPT_ONE_DEC;
    missing = kept - parse_i.frac_count;

    // Pad the kept fraction digits out to the full kept count.
    unique case (missing)
      2'd0:    frac_pad = parse_i.frac_digits;
      2'd1:    frac_pad = dtfp_pkg::FRAC_BITS'(parse_i.frac_digits * 10'd10);
      2'd2:    frac_pad = dtfp_pkg::FRAC_BITS'(parse_i.frac_digits * 10'd100);
      default: frac_pad = dtfp_pkg::FRAC_BITS'(parse_i.frac_digits * 10'd1000);
    endcase

    // Round half away from zero by dropping the last digit.
    rnd_sum = {1'b0, frac_pad} + (dtfp_pkg::FRAC_BITS + 1)'(5);
    rprod   = dtfp_pkg::RPROD_BITS'(rnd_sum) * dtfp_pkg::RPROD_BITS'(dtfp_pkg::RECIP);
    rnd     = dtfp_pkg::RND_BITS'(rprod >> dtfp_pkg::RECIP_SHIFT);

    unique case (mode_i)
      dtfp_pkg::MODE_TWO_DEC:
        mag = dtfp_pkg::MAG_BITS'(parse_i.acc) * dtfp_pkg::MAG_BITS'(100)
              + dtfp_pkg::MAG_BITS'(rnd);
      dtfp_pkg::MODE_ONE_DEC:
        mag = dtfp_pkg::MAG_BITS'(parse_i.acc) * dtfp_pkg::MAG_BITS'(10)
              + dtfp_pkg::MAG_BITS'(rnd);
      default:
        // A rounded tenth can only carry into the units when it reaches ten.
        mag = dtfp_pkg::MAG_BITS'(parse_i.acc)
              + dtfp_pkg::MAG_BITS'(rnd == dtfp_pkg::RND_BITS'(10));
    endcase

    limit   = parse_i.negative ? dtfp_pkg::MAG_CAP
                               : dtfp_pkg::MAG_CAP - dtfp_pkg::MAG_BITS'(1);
    ovf     = parse_i.saturated || (mag > limit);
    mag_sel = ovf ? limit : mag;
    mag_low = mag_sel[dtfp_pkg::VALUE_BITS-1:0];

    scaled_o.value    = parse_i.negative ? (~mag_low + dtfp_pkg::VALUE_BITS'(1)) : mag_low;
    scaled_o.overflow = ovf;
  end

endmodule

`default_nettype wire

/* rtl/core/decimal_text_to_fixed_point.sv */
// Decimal text to fixed-point parser. Characters enter one per request on the
// input channel; leading whitespace, one sign, integer digits, a point and
// fraction digits are gathered, and the first other character ends the number
// and produces one result request carrying the signed, rounded and saturated
// value, the count of characters used and that stop character. The block takes
// one character every cycle unless a stop character waits on a held result:
// each character is registered in the input register, then folded into the
// parse state by a multiply-by-ten accumulate; for a stop character the
// rounding and scaling run combinationally and the result is loaded into the
// output register once it is free. The result register lets the next number
// start while a result is still held. The user must write decimal_mode only
// between numbers; the block does not enforce it. Code 3 acts as integer mode.

`default_nettype none

module decimal_text_to_fixed_point (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [1:0]                      cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [7:0]                      text_char_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic signed [dtfp_pkg::VALUE_BITS-1:0] value_o,
  output logic [dtfp_pkg::COUNT_BITS-1:0]      chars_used_o,
  output logic [7:0]                           stop_char_o,
  output logic                                 overflow_o
);

  typedef enum logic {
    PH_SPACE,
    PH_BODY
  } phase_e;

  dtfp_pkg::mode_e                 mode_q;
  logic                            char_valid_q;
  logic [7:0]                      char_q;
  phase_e                          phase_q, phase_d;
  dtfp_pkg::parse_t                parse_q, parse_d;
  logic [dtfp_pkg::COUNT_BITS-1:0] count_q, count_d, count_inc;
  logic                            out_valid_q;
  logic [dtfp_pkg::VALUE_BITS-1:0] value_q;
  logic [dtfp_pkg::COUNT_BITS-1:0] chars_used_q;
  logic [7:0]                      stop_char_q;
  logic                            overflow_q;

  logic                            is_space, is_sign, is_dot, is_digit;
  logic                            body_char, stop, out_free, proc, accept;
  logic [1:0]                      kept;
  logic [3:0]                      digit;
  logic [dtfp_pkg::ACC_X_BITS-1:0] acc_next;
  dtfp_pkg::scaled_t               scaled;

  dtfp_scale u_scale (
    .mode_i   (mode_q),
    .parse_i  (parse_q),
    .scaled_o (scaled)
  );

  always_comb begin
    is_space  = (char_q == dtfp_pkg::CHAR_SPACE) ||
                ((char_q >= dtfp_pkg::CHAR_TAB) && (char_q <= dtfp_pkg::CHAR_CR));
    is_sign   = (char_q == dtfp_pkg::CHAR_MINUS) || (char_q == dtfp_pkg::CHAR_PLUS);
    is_dot    = (char_q == dtfp_pkg::CHAR_DOT);
    is_digit  = (char_q >= dtfp_pkg::CHAR_ZERO) && (char_q <= dtfp_pkg::CHAR_NINE);
    digit     = char_q[3:0];
    // Whitespace and a sign are only swallowed before the number body starts.
    body_char = !((phase_q == PH_SPACE) && (is_space || is_sign));
    stop      = body_char && !is_dot && !is_digit;
    out_free  = !out_valid_q || !out_stall_i;
    proc      = char_valid_q && (!stop || out_free);
    kept      = (mode_q == dtfp_pkg::MODE_TWO_DEC) ? dtfp_pkg::KEPT_TWO_DEC
                                                   : dtfp_pkg::KEPT_ONE_DEC;
    count_inc = (count_q == {dtfp_pkg::COUNT_BITS{1'b1}}) ? count_q
                                                          : count_q + 1'b1;
    acc_next  = dtfp_pkg::ACC_X_BITS'(parse_q.acc) * dtfp_pkg::ACC_X_BITS'(10)
                + dtfp_pkg::ACC_X_BITS'(digit);
  end

  assign in_stall_o = char_valid_q && !proc;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d = phase_q;
    parse_d = parse_q;
    count_d = count_q;
    if (!body_char) begin
      count_d = count_inc;
      if (is_sign) begin
        phase_d          = PH_BODY;
        parse_d.negative = (char_q == dtfp_pkg::CHAR_MINUS);
      end
    end else if (is_dot) begin
      phase_d            = PH_BODY;
      parse_d.point_seen = 1'b1;
      count_d            = count_inc;
    end else if (is_digit) begin
      phase_d = PH_BODY;
      count_d = count_inc;
      if (parse_q.point_seen) begin
        if (parse_q.frac_count < kept) begin
          parse_d.frac_digits =
            dtfp_pkg::FRAC_BITS'(parse_q.frac_digits * dtfp_pkg::FRAC_BITS'(10))
            + dtfp_pkg::FRAC_BITS'(digit);
          parse_d.frac_count  = parse_q.frac_count + 2'd1;
        end
      end else if (!parse_q.saturated) begin
        if (acc_next > dtfp_pkg::ACC_X_BITS'(dtfp_pkg::MAG_CAP)) begin
          parse_d.saturated = 1'b1;
        end else begin
          parse_d.acc = acc_next[dtfp_pkg::ACC_BITS-1:0];
        end
      end
    end else begin
      phase_d = PH_SPACE;
      parse_d = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= dtfp_pkg::MODE_TWO_DEC;
      char_valid_q <= 1'b0;
      phase_q      <= PH_SPACE;
      parse_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= (cfg_wdata_i == dtfp_pkg::MODE_CODE_ALIAS) ? dtfp_pkg::MODE_INTEGER
                                                             : dtfp_pkg::mode_e'(cfg_wdata_i);
      end
      if (accept) begin
        char_valid_q <= 1'b1;
      end else if (proc) begin
        char_valid_q <= 1'b0;
      end
      if (proc) begin
        phase_q <= phase_d;
        parse_q <= parse_d;
        count_q <= count_d;
      end
      if (proc && stop) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= text_char_i;
    end
    if (proc && stop) begin
      value_q      <= scaled.value;
      overflow_q   <= scaled.overflow;
      chars_used_q <= count_q;
      stop_char_q  <= char_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign chars_used_o = chars_used_q;
  assign stop_char_o  = stop_char_q;
  assign overflow_o   = overflow_q;

endmodule

`default_nettype wire

/* rtl/core/dtfp_checker.sv */
`default_nettype none

`include "decimal_text_to_fixed_point_defines.svh"

module dtfp_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            cfg_we_i,
  input wire logic [1:0]                      cfg_wdata_i,
  input wire logic                            in_valid_i,
  input wire logic                            in_stall_o,
  input wire logic [7:0]                      text_char_i,
  input wire logic                            out_valid_o,
  input wire logic                            out_stall_i,
  input wire logic [dtfp_pkg::VALUE_BITS-1:0] value_o,
  input wire logic [dtfp_pkg::COUNT_BITS-1:0] chars_used_o,
  input wire logic [7:0]                      stop_char_o,
  input wire logic                            overflow_o
);

  localparam logic [dtfp_pkg::VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(dtfp_pkg::VALUE_BITS-1){1'b1}}};
  localparam logic [dtfp_pkg::VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(dtfp_pkg::VALUE_BITS-1){1'b0}}};

  logic unused_inputs;
  assign unused_inputs = cfg_we_i ^ (^cfg_wdata_i) ^ in_valid_i ^ in_stall_o ^ (^text_char_i);

  // A held result request keeps its payload.
  `DTFP_ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(value_o) && $stable(chars_used_o) && $stable(stop_char_o) && $stable(overflow_o))

  // A saturated result sits at one of the two extremes.
  `DTFP_ASSERT_IMPLIES(a_overflow_extreme, clk_i, rst_ni, out_valid_o && overflow_o,
                       (value_o == VALUE_MAX) || (value_o == VALUE_MIN))

  // Digits and points are always part of the number, so they never stop it.
  `DTFP_ASSERT_IMPLIES(a_stop_not_numeric, clk_i, rst_ni, out_valid_o,
                       (stop_char_o != dtfp_pkg::CHAR_DOT) && ((stop_char_o < dtfp_pkg::CHAR_ZERO) || (stop_char_o > dtfp_pkg::CHAR_NINE)))

  // With nothing consumed there is nothing to carry a value.
  `DTFP_ASSERT_IMPLIES(a_empty_is_zero, clk_i, rst_ni, out_valid_o && (chars_used_o == '0),
                       (value_o == '0) && !overflow_o)

endmodule

bind decimal_text_to_fixed_point dtfp_checker u_dtfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_we_i     (cfg_we_i),
  .cfg_wdata_i  (cfg_wdata_i),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .text_char_i  (text_char_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .value_o      (value_o),
  .chars_used_o (chars_used_o),
  .stop_char_o  (stop_char_o),
  .overflow_o   (overflow_o)
);

`default_nettype wire
